// ===== hdl/stepper_phase_sequencer_uart_defines.svh =====
// assertion macros for the stepper phase sequencer
// used by the top rtl file of the block, no other dependencies
`ifndef STEPPER_PHASE_SEQUENCER_UART_DEFINES_SVH
`define STEPPER_PHASE_SEQUENCER_UART_DEFINES_SVH
`ifndef SYNTHESIS
`define SPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sps assertion failed");
`define SPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sps assertion failed");
`else
`define SPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/sps_pkg.sv =====
// shared types, constants and microcode rom of the stepper phase sequencer
// no dependencies
package sps_pkg;

    localparam int TABLE_STEPS_DEF = 16;
    localparam int IDX_W           = 4;
    localparam int PHASE_W         = 6;
    localparam int PERIOD_W        = 16;
    localparam int CFG_W           = 48;
    localparam int CFG_IDX_W       = 1;
    localparam int PC_W            = 4;
    localparam int CNT_W           = 5;
    localparam int BANNER_LEN      = 17;
    localparam int DEC_DIGITS      = 5;
    localparam int DEC_W           = PERIOD_W + 1;

    localparam logic [PERIOD_W-1:0] PERIOD_RST   = 16'd100;
    localparam logic [PERIOD_W-1:0] PERIOD_DEC   = 16'd5;
    localparam logic [PERIOD_W-1:0] PERIOD_INC   = 16'd1;
    localparam logic [CFG_W-1:0]    TAB_LOW_RST  = 48'd3161767202821;
    localparam logic [CFG_W-1:0]    TAB_HIGH_RST = 48'd3642937794566;

    localparam logic [1:0] FUNC_TICK   = 2'd0;
    localparam logic [1:0] FUNC_BYTE   = 2'd1;
    localparam logic [1:0] FUNC_BUTTON = 2'd2;
    localparam logic [1:0] FUNC_NONE   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_HIGH = 1'b1;

    localparam logic KIND_PHASE = 1'b0;
    localparam logic KIND_TX    = 1'b1;

    localparam logic [7:0] CH_A    = 8'h41;
    localparam logic [7:0] CH_B    = 8'h42;
    localparam logic [7:0] CH_C    = 8'h43;
    localparam logic [7:0] CH_D    = 8'h44;
    localparam logic [7:0] CH_CR   = 8'h0d;
    localparam logic [7:0] CH_LF   = 8'h0a;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NUL  = 8'h00;

    localparam logic [2:0] DEC_POS_ONES = 3'd4;

    // multiples 1..9 of each decimal weight, most significant weight first
    localparam logic [DEC_W-1:0] DEC_THRESH [DEC_DIGITS][9] = '{
        '{17'd10000, 17'd20000, 17'd30000, 17'd40000, 17'd50000,
          17'd60000, 17'd70000, 17'd80000, 17'd90000},
        '{17'd1000, 17'd2000, 17'd3000, 17'd4000, 17'd5000,
          17'd6000, 17'd7000, 17'd8000, 17'd9000},
        '{17'd100, 17'd200, 17'd300, 17'd400, 17'd500,
          17'd600, 17'd700, 17'd800, 17'd900},
        '{17'd10, 17'd20, 17'd30, 17'd40, 17'd50,
          17'd60, 17'd70, 17'd80, 17'd90},
        '{17'd1, 17'd2, 17'd3, 17'd4, 17'd5,
          17'd6, 17'd7, 17'd8, 17'd9}
    };

    localparam logic [PC_W-1:0] PC_TICK   = 4'd0;
    localparam logic [PC_W-1:0] PC_CMD    = 4'd1;
    localparam logic [PC_W-1:0] PC_CRLF   = 4'd7;
    localparam logic [PC_W-1:0] PC_BANNER = 4'd9;

    typedef enum logic [2:0] {
        OP_TICK,
        OP_CMD,
        OP_DIGIT,
        OP_CHAR,
        OP_BANNER
    } t_op;

    typedef struct packed {
        t_op             op;
        logic [2:0]      pow_sel;
        logic [7:0]      ch;
        logic            last;
        logic            fin;
        logic [PC_W-1:0] target;
    } t_uop;

    typedef struct packed {
        logic               kind;
        logic [PHASE_W-1:0] phase_out;
        logic               stepped;
        logic [7:0]         tx_char;
        logic               last;
    } t_rsp;

    function automatic t_uop uop_rom(input logic [PC_W-1:0] pc);
        t_uop u;
        u = '{op: OP_CMD, pow_sel: 3'd0, ch: CH_NUL, last: 1'b0, fin: 1'b1, target: PC_TICK};
        unique case (pc)
            4'd0: u = '{op: OP_TICK, pow_sel: 3'd0, ch: CH_NUL, last: 1'b1, fin: 1'b1,
                        target: PC_TICK};
            4'd1: u = '{op: OP_CMD, pow_sel: 3'd0, ch: CH_NUL, last: 1'b0, fin: 1'b0,
                        target: PC_TICK};
            4'd2: u = '{op: OP_DIGIT, pow_sel: 3'd0, ch: CH_NUL, last: 1'b0, fin: 1'b0,
                        target: PC_TICK};
            4'd3: u = '{op: OP_DIGIT, pow_sel: 3'd1, ch: CH_NUL, last: 1'b0, fin: 1'b0,
                        target: PC_TICK};
            4'd4: u = '{op: OP_DIGIT, pow_sel: 3'd2, ch: CH_NUL, last: 1'b0, fin: 1'b0,
                        target: PC_TICK};
            4'd5: u = '{op: OP_DIGIT, pow_sel: 3'd3, ch: CH_NUL, last: 1'b0, fin: 1'b0,
                        target: PC_TICK};
            4'd6: u = '{op: OP_DIGIT, pow_sel: DEC_POS_ONES, ch: CH_NUL, last: 1'b0,
                        fin: 1'b0, target: PC_TICK};
            4'd7: u = '{op: OP_CHAR, pow_sel: 3'd0, ch: CH_CR, last: 1'b0, fin: 1'b0,
                        target: PC_TICK};
            4'd8: u = '{op: OP_CHAR, pow_sel: 3'd0, ch: CH_LF, last: 1'b1, fin: 1'b1,
                        target: PC_TICK};
            4'd9: u = '{op: OP_BANNER, pow_sel: 3'd0, ch: CH_NUL, last: 1'b0, fin: 1'b0,
                        target: PC_CRLF};
            default: ;
        endcase
        return u;
    endfunction

    function automatic logic [7:0] banner_char(input logic [CNT_W-1:0] i);
        logic [7:0] c;
        c = CH_NUL;
        unique case (i)
            5'd0:  c = 8'h4b;
            5'd1:  c = 8'h6f;
            5'd2:  c = 8'h6b;
            5'd3:  c = 8'h6f;
            5'd4:  c = 8'h73;
            5'd5:  c = 8'h7a;
            5'd6:  c = 8'h20;
            5'd7:  c = 8'h54;
            5'd8:  c = 8'h79;
            5'd9:  c = 8'h20;
            5'd10: c = 8'h42;
            5'd11: c = 8'h6f;
            5'd12: c = 8'h6f;
            5'd13: c = 8'h43;
            5'd14: c = 8'h49;
            5'd15: c = 8'h45;
            5'd16: c = 8'h21;
            default: ;
        endcase
        return c;
    endfunction

endpackage

// ===== hdl/sps_in_if.sv =====
// request channel of the stepper phase sequencer
// depends on sps_pkg
interface sps_in_if;
    import sps_pkg::*;

    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] rx_byte;

    modport source (output valid, output func, output rx_byte, input ready);
    modport sink (input valid, input func, input rx_byte, output ready);
endinterface

// ===== hdl/sps_out_if.sv =====
// result channel of the stepper phase sequencer
// depends on sps_pkg
interface sps_out_if;
    import sps_pkg::*;

    logic               valid;
    logic               ready;
    logic               kind;
    logic [PHASE_W-1:0] phase_out;
    logic               stepped;
    logic [7:0]         tx_char;
    logic               last;

    modport source (output valid, output kind, output phase_out, output stepped,
                    output tx_char, output last, input ready);
    modport sink (input valid, input kind, input phase_out, input stepped,
                  input tx_char, input last, output ready);
endinterface

// ===== hdl/stepper_phase_sequencer_uart.sv =====
// Stepper phase sequencer with a serial command and echo path. A tick request
// is accepted and then runs one microcode step, giving one phase result; a
// command byte is accepted and runs a command step, five decimal digit steps,
// CR and LF, giving three to seven characters; a button request is accepted and
// runs seventeen banner steps, CR and LF. Each step that emits waits while
// the output register is still held by the sink. One request is in work at a
// time; the microcode step counter walks a ten-word control rom.
// depends on sps_pkg, sps_in_if, sps_out_if and the defines header
`include "stepper_phase_sequencer_uart_defines.svh"

module stepper_phase_sequencer_uart #(
    parameter int TABLE_STEPS = sps_pkg::TABLE_STEPS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sps_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sps_pkg::CFG_W-1:0]      i_cfg_data,
    sps_in_if.sink                         i_req,
    sps_out_if.source                      o_rsp
);
    import sps_pkg::*;

    logic [CFG_W-1:0]    r_tab_low, n_tab_low;
    logic [CFG_W-1:0]    r_tab_high, n_tab_high;
    logic [PERIOD_W-1:0] r_count, n_count;
    logic [PERIOD_W-1:0] r_period, n_period;
    logic                r_dir_up, n_dir_up;
    logic [IDX_W-1:0]    r_index, n_index;
    logic [PHASE_W-1:0]  r_pattern, n_pattern;
    logic                r_busy, n_busy;
    logic [PC_W-1:0]     r_pc, n_pc;
    logic                r_out_valid, n_out_valid;

    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [7:0]          r_byte, n_byte;
    logic [PERIOD_W-1:0] r_val, n_val;
    logic                r_nz, n_nz;
    t_rsp                r_out, n_out;

    t_uop                uop;
    logic                req_acc;
    logic                rsp_acc;
    logic                out_free;
    logic                emit;
    logic                advance;
    logic                hit;
    logic [IDX_W-1:0]    idx_up, idx_dn, idx_step;
    logic [CFG_W-1:0]    tab_word;
    logic [PHASE_W-1:0]  tab_pat;
    logic [3:0]          digit;
    logic [DEC_W-1:0]    sub;
    logic [PERIOD_W-1:0] rem;
    logic                show;
    logic [PERIOD_W-1:0] cmd_period;
    t_rsp                rsp;

    assign uop      = uop_rom(r_pc);
    assign req_acc  = i_req.valid && i_req.ready;
    assign rsp_acc  = o_rsp.valid && o_rsp.ready;
    assign out_free = !r_out_valid || o_rsp.ready;

    assign i_req.ready     = !r_busy;
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.kind      = r_out.kind;
    assign o_rsp.phase_out = r_out.phase_out;
    assign o_rsp.stepped   = r_out.stepped;
    assign o_rsp.tx_char   = r_out.tx_char;
    assign o_rsp.last      = r_out.last;

    // step index and table lookup
    always_comb begin
        hit      = (r_count == r_period);
        idx_up   = (r_index == IDX_W'(TABLE_STEPS - 1)) ? '0 : r_index + 1'b1;
        idx_dn   = (r_index == '0) ? IDX_W'(TABLE_STEPS - 1) : r_index - 1'b1;
        idx_step = r_dir_up ? idx_up : idx_dn;
        tab_word = idx_step[IDX_W-1] ? r_tab_high : r_tab_low;
        tab_pat  = tab_word[PHASE_W*idx_step[IDX_W-2:0] +: PHASE_W];
    end

    // one decimal digit per step
    always_comb begin
        digit = '0;
        for (int k = 0; k < 9; k++) begin
            if ({1'b0, r_val} >= DEC_THRESH[uop.pow_sel][k]) begin
                digit = digit + 4'd1;
            end
        end
        sub  = (digit == '0) ? '0 : DEC_THRESH[uop.pow_sel][digit - 4'd1];
        rem  = r_val - sub[PERIOD_W-1:0];
        show = r_nz || (digit != '0) || (uop.pow_sel == DEC_POS_ONES);
    end

    always_comb begin
        cmd_period = r_period;
        case (r_byte)
            CH_A:    cmd_period = r_period - PERIOD_DEC;
            CH_B:    cmd_period = r_period + PERIOD_INC;
            default: ;
        endcase
    end

    // control word decode
    always_comb begin
        emit = 1'b0;
        rsp  = '{kind: KIND_TX, phase_out: r_pattern, stepped: 1'b0, tx_char: CH_NUL,
                 last: uop.last};
        unique case (uop.op)
            OP_TICK: begin
                emit          = 1'b1;
                rsp.kind      = KIND_PHASE;
                rsp.phase_out = hit ? tab_pat : r_pattern;
                rsp.stepped   = hit;
            end
            OP_CMD: ;
            OP_DIGIT: begin
                emit        = show;
                rsp.tx_char = CH_ZERO + {4'd0, digit};
            end
            OP_CHAR: begin
                emit        = 1'b1;
                rsp.tx_char = uop.ch;
            end
            OP_BANNER: begin
                emit        = 1'b1;
                rsp.tx_char = banner_char(r_cnt);
            end
            default: ;
        endcase
        advance = r_busy && (!emit || out_free);
    end

    always_comb begin
        n_tab_low   = r_tab_low;
        n_tab_high  = r_tab_high;
        n_count     = r_count;
        n_period    = r_period;
        n_dir_up    = r_dir_up;
        n_index     = r_index;
        n_pattern   = r_pattern;
        n_busy      = r_busy;
        n_pc        = r_pc;
        n_out_valid = r_out_valid;
        n_cnt       = r_cnt;
        n_byte      = r_byte;
        n_val       = r_val;
        n_nz        = r_nz;
        n_out       = r_out;

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PHASE_LOW:  n_tab_low  = i_cfg_data;
                CFG_PHASE_HIGH: n_tab_high = i_cfg_data;
                default: ;
            endcase
        end

        if (req_acc) begin
            n_byte = i_req.rx_byte;
            n_cnt  = '0;
            unique case (i_req.func)
                FUNC_TICK: begin
                    n_busy = 1'b1;
                    n_pc   = PC_TICK;
                end
                FUNC_BYTE: begin
                    n_busy = 1'b1;
                    n_pc   = PC_CMD;
                end
                FUNC_BUTTON: begin
                    n_busy = 1'b1;
                    n_pc   = PC_BANNER;
                end
                default: ;
            endcase
        end

        if (rsp_acc) begin
            n_out_valid = 1'b0;
        end

        if (advance) begin
            if (emit) begin
                n_out_valid = 1'b1;
                n_out       = rsp;
            end
            unique case (uop.op)
                OP_TICK: begin
                    if (hit) begin
                        n_count   = '0;
                        n_index   = idx_step;
                        n_pattern = tab_pat;
                    end else begin
                        n_count = r_count + 1'b1;
                    end
                end
                OP_CMD: begin
                    n_period = cmd_period;
                    n_val    = cmd_period;
                    n_nz     = 1'b0;
                    if (r_byte == CH_C) begin
                        n_dir_up = 1'b0;
                    end else if (r_byte == CH_D) begin
                        n_dir_up = 1'b1;
                    end
                end
                OP_DIGIT: begin
                    n_val = rem;
                    n_nz  = r_nz || show;
                end
                default: ;
            endcase

            if (uop.fin) begin
                n_busy = 1'b0;
            end else if (uop.op == OP_BANNER) begin
                if (r_cnt == CNT_W'(BANNER_LEN - 1)) begin
                    n_pc  = uop.target;
                    n_cnt = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end else begin
                n_pc = r_pc + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tab_low   <= TAB_LOW_RST;
            r_tab_high  <= TAB_HIGH_RST;
            r_count     <= '0;
            r_period    <= PERIOD_RST;
            r_dir_up    <= 1'b0;
            r_index     <= '0;
            r_pattern   <= '0;
            r_busy      <= 1'b0;
            r_pc        <= PC_TICK;
            r_out_valid <= 1'b0;
        end else begin
            r_tab_low   <= n_tab_low;
            r_tab_high  <= n_tab_high;
            r_count     <= n_count;
            r_period    <= n_period;
            r_dir_up    <= n_dir_up;
            r_index     <= n_index;
            r_pattern   <= n_pattern;
            r_busy      <= n_busy;
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_byte <= n_byte;
        r_val  <= n_val;
        r_nz   <= n_nz;
        r_out  <= n_out;
    end

    `SPS_ASSERT_NXT(a_busy_after_req, i_clk, i_rst_n, req_acc && i_req.func != FUNC_NONE, r_busy)
    `SPS_ASSERT_NXT(a_out_held, i_clk, i_rst_n, r_out_valid && !o_rsp.ready, r_out_valid && $stable(r_out))
    `SPS_ASSERT_IMP(a_index_range, i_clk, i_rst_n, 1'b1, {1'b0, r_index} < (IDX_W + 1)'(TABLE_STEPS))
    `SPS_ASSERT_IMP(a_step_clears_count, i_clk, i_rst_n, r_out_valid && r_out.kind == KIND_PHASE && r_out.stepped, r_count == '0)

endmodule

// ===== verif/sps_tb_pkg.sv =====
// predictor and result checker for the stepper phase sequencer testbench
// depends on sps_pkg
package sps_tb_pkg;
    import sps_pkg::*;

    localparam logic [8*BANNER_LEN-1:0] BANNER_TEXT = "Kokosz Ty BooCIE!";

    class drive_echo_model;
        logic [PERIOD_W-1:0] tick_count;
        logic [PERIOD_W-1:0] step_period;
        logic                dir_up;
        logic [IDX_W-1:0]    step_idx;
        logic [PHASE_W-1:0]  coil;
        logic [CFG_W-1:0]    tab_lo;
        logic [CFG_W-1:0]    tab_hi;
        t_rsp                awaited[$];
        int                  errors;

        function new();
            tick_count  = '0;
            step_period = PERIOD_RST;
            dir_up      = 1'b0;
            step_idx    = '0;
            coil        = '0;
            tab_lo      = TAB_LOW_RST;
            tab_hi      = TAB_HIGH_RST;
            errors      = 0;
        endfunction

        function void set_tables(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi);
            tab_lo = lo;
            tab_hi = hi;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void push_rsp(input logic kind, input logic stp, input logic [7:0] ch,
                               input logic fin);
            t_rsp r;
            r.kind      = kind;
            r.phase_out = coil;
            r.stepped   = stp;
            r.tx_char   = ch;
            r.last      = fin;
            awaited.push_back(r);
        endfunction

        function void push_text(input logic [7:0] chars[$]);
            for (int i = 0; i < chars.size(); i++) begin
                push_rsp(KIND_TX, 1'b0, chars[i], i == chars.size() - 1);
            end
        endfunction

        function void take_request(input logic [1:0] func, input logic [7:0] rx);
            logic [7:0]          chars[$];
            logic [PERIOD_W-1:0] v;
            case (func)
                FUNC_TICK: begin
                    if (tick_count == step_period) begin
                        tick_count = '0;
                        step_idx   = dir_up ? step_idx + 1'b1 : step_idx - 1'b1;
                        coil       = step_idx[3] ? tab_hi[PHASE_W*step_idx[2:0] +: PHASE_W]
                                                 : tab_lo[PHASE_W*step_idx[2:0] +: PHASE_W];
                        push_rsp(KIND_PHASE, 1'b1, CH_NUL, 1'b1);
                    end else begin
                        tick_count = tick_count + 1'b1;
                        push_rsp(KIND_PHASE, 1'b0, CH_NUL, 1'b1);
                    end
                end
                FUNC_BYTE: begin
                    case (rx)
                        CH_A: step_period = step_period - PERIOD_DEC;
                        CH_B: step_period = step_period + PERIOD_INC;
                        CH_C: dir_up = 1'b0;
                        CH_D: dir_up = 1'b1;
                        default: ;
                    endcase
                    v = step_period;
                    do begin
                        chars.push_front(CH_ZERO + 8'(v % 16'd10));
                        v = v / 16'd10;
                    end while (v != 0);
                    chars.push_back(CH_CR);
                    chars.push_back(CH_LF);
                    push_text(chars);
                end
                FUNC_BUTTON: begin
                    for (int i = 0; i < BANNER_LEN; i++) begin
                        chars.push_back(BANNER_TEXT[8*(BANNER_LEN-1-i) +: 8]);
                    end
                    chars.push_back(CH_CR);
                    chars.push_back(CH_LF);
                    push_text(chars);
                end
                default: ;
            endcase
        endfunction

        function void note_error(input string what, input t_rsp want, input t_rsp got);
            errors++;
            if (errors <= 10) begin
                $display("%s: expected kind=%0d phase=%02h stepped=%0d char=%02h last=%0d, got kind=%0d phase=%02h stepped=%0d char=%02h last=%0d",
                         what, want.kind, want.phase_out, want.stepped, want.tx_char,
                         want.last, got.kind, got.phase_out, got.stepped, got.tx_char,
                         got.last);
            end
        endfunction

        function void check_result(input t_rsp got);
            t_rsp want;
            if (awaited.size() == 0) begin
                note_error("result with nothing pending", '0, got);
            end else begin
                want = awaited.pop_front();
                if (got.kind !== want.kind || got.phase_out !== want.phase_out ||
                    got.stepped !== want.stepped || got.tx_char !== want.tx_char ||
                    got.last !== want.last) begin
                    note_error("result mismatch", want, got);
                end
            end
        endfunction

        function void close_out();
            if (awaited.size() != 0) begin
                errors += awaited.size();
                $display("%0d results still pending", awaited.size());
            end
        endfunction
    endclass

endpackage

// ===== verif/tb_stepper_phase_sequencer_uart.sv =====
// top of the stepper phase sequencer testbench: clock, reset, request and result drivers
// depends on sps_pkg, sps_in_if, sps_out_if, sps_tb_pkg and the block itself
module tb_stepper_phase_sequencer_uart;
    import sps_pkg::*;
    import sps_tb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int SETTLE_CYCLES = 30;
    localparam int HOLD_CYCLES   = 400;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    sps_in_if  req_ch ();
    sps_out_if rsp_ch ();

    drive_echo_model sb;
    bit              no_idle = 1'b0;
    int              hold_len = 0;
    int              cycle_count = 0;

    stepper_phase_sequencer_uart u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_stepper_phase_sequencer_uart: errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            sb.check_result(t_rsp'{rsp_ch.kind, rsp_ch.phase_out, rsp_ch.stepped,
                                   rsp_ch.tx_char, rsp_ch.last});
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int unsigned gap;
        rsp_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_len > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (hold_len) @(posedge i_clk);
                hold_len = 0;
            end else begin
                gap = no_idle ? 0 : $urandom_range(0, 6);
                if (gap != 0) begin
                    rsp_ch.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                rsp_ch.ready <= 1'b1;
                do @(posedge i_clk);
                while (!(rsp_ch.valid && rsp_ch.ready) && hold_len == 0);
            end
        end
    end

    task automatic send_request(input logic [1:0] f, input logic [7:0] b);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.func    <= f;
        req_ch.rx_byte <= b;
        do @(posedge i_clk);
        while (!(req_ch.valid && req_ch.ready));
        sb.take_request(f, b);
    endtask

    task automatic send_random();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 58)
            send_request(FUNC_TICK, 8'($urandom));
        else if (r < 66)
            send_request(FUNC_BYTE, $urandom_range(0, 1) ? CH_C : CH_D);
        else if (r < 71)
            send_request(FUNC_BYTE, CH_B);
        else if (r < 73)
            send_request(FUNC_BYTE, CH_A);
        else if (r < 83)
            send_request(FUNC_BYTE, 8'($urandom_range(0, 255)));
        else if (r < 93)
            send_request(FUNC_BUTTON, 8'($urandom));
        else
            send_request(FUNC_NONE, 8'($urandom));
    endtask

    task automatic settle();
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_tables(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_PHASE_LOW;
        i_cfg_data <= lo;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_PHASE_HIGH;
        i_cfg_data <= hi;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_tables(lo, hi);
    endtask

    initial begin
        logic [PERIOD_W-1:0] target;
        logic [CFG_W-1:0]    lo;
        logic [CFG_W-1:0]    hi;

        sb = new();
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= CFG_PHASE_LOW;
        i_cfg_data     <= '0;
        req_ch.valid   <= 1'b0;
        req_ch.func    <= FUNC_TICK;
        req_ch.rx_byte <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed requests on the reset tables
        send_request(FUNC_NONE, 8'hff);
        send_request(FUNC_BUTTON, 8'h00);
        send_request(FUNC_BYTE, 8'h00);
        send_request(FUNC_BYTE, 8'hff);
        send_request(FUNC_BYTE, CH_B);
        send_request(FUNC_BYTE, CH_A);
        send_request(FUNC_BYTE, CH_ZERO);
        send_request(FUNC_BYTE, CH_D);
        repeat (4) send_request(FUNC_TICK, 8'h00);
        send_request(FUNC_BYTE, CH_C);
        repeat (4) send_request(FUNC_TICK, 8'hff);
        send_request(FUNC_NONE, 8'h00);
        send_request(FUNC_BUTTON, 8'hff);

        // period down through zero and back up through 65535
        while (sb.step_period >= PERIOD_DEC) send_request(FUNC_BYTE, CH_A);
        send_request(FUNC_BYTE, CH_A);
        while (sb.step_period != 0) send_request(FUNC_BYTE, CH_B);

        // counter above period keeps counting up
        no_idle = 1'b1;
        repeat (8) send_request(FUNC_TICK, 8'($urandom));
        no_idle = 1'b0;

        for (int ph = 0; ph < 5; ph++) begin
            settle();
            case (ph)
                0: begin
                    lo = '1;
                    hi = '1;
                end
                1: begin
                    lo = '0;
                    hi = '0;
                end
                default: begin
                    lo = CFG_W'({$urandom, $urandom});
                    hi = CFG_W'({$urandom, $urandom});
                end
            endcase
            load_tables(lo, hi);
            no_idle = (ph == 2);
            target = PERIOD_W'($urandom_range(4, 12));
            if (sb.step_period > 16'd65000) begin
                while (sb.step_period != 0) send_request(FUNC_BYTE, CH_B);
            end
            while (sb.step_period > target) send_request(FUNC_BYTE, CH_A);
            while (sb.step_period < target) send_request(FUNC_BYTE, CH_B);
            repeat (24) send_random();
        end

        // long result stall while requests keep coming
        settle();
        load_tables(CFG_W'({$urandom, $urandom}), CFG_W'({$urandom, $urandom}));
        no_idle = 1'b1;
        hold_len = HOLD_CYCLES;
        repeat (16) begin
            if ($urandom_range(0, 1))
                send_request(FUNC_BUTTON, 8'($urandom));
            else
                send_request(FUNC_BYTE, 8'($urandom));
        end
        no_idle = 1'b0;

        settle();
        sb.close_out();
        if (sb.errors == 0)
            $display("tb_stepper_phase_sequencer_uart: clean");
        else
            $display("tb_stepper_phase_sequencer_uart: errors");
        $finish;
    end

endmodule
